// ===== design/round_robin_thread_slot_scheduler_assert.svh =====
// Assertion macros for the round-robin thread slot scheduler.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ROUND_ROBIN_THREAD_SLOT_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SLOT_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge.
`define RRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition implies another in the next cycle.
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RRTS_ASSERT(lbl, prop, msg)
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/rrts_pkg.sv =====
`default_nettype none

package rrts_pkg;

  // Fixed field widths of the command and result words
  localparam int unsigned SlotFieldW = 6;
  localparam int unsigned StackW     = 32;
  // Wide enough for any slot index up to the largest slot count
  localparam int unsigned IdxMaxW    = 8;
  localparam logic [StackW-1:0] StackLimit = 32'd1048576;

  typedef enum logic [1:0] {
    CmdYield  = 2'd0,
    CmdExit   = 2'd1,
    CmdCreate = 2'd2
  } command_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadSize = 2'd1,
    StFull    = 2'd2,
    StNoLive  = 2'd3
  } status_e;

  typedef enum logic {
    SIdle = 1'b0,
    SSeek = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [StackW-1:0] stack_bytes;
  } cmd_word_t;

  typedef struct packed {
    logic [SlotFieldW-1:0] from_slot;
    logic [SlotFieldW-1:0] to_slot;
    logic [SlotFieldW-1:0] created_slot;
    logic [1:0]            status;
  } res_word_t;

  // Control broadcast from the sequencer to every slot cell
  typedef struct packed {
    logic               load_tok;
    logic               shift_tok;
    logic               find_free;
    logic               set_live;
    logic               clr_run;
    logic [IdxMaxW-1:0] start_idx;
    logic [IdxMaxW-1:0] run_idx;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/rrts_slot_cell.sv =====
`default_nettype none

module rrts_slot_cell
  import rrts_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cell_ctrl_t  ctrl_i,
  input  wire         tok_prev_i,
  output logic        tok_o,
  output logic        live_o,
  output logic        hit_o
);

  localparam logic [IdxMaxW-1:0] MyIdx = IdxMaxW'(INDEX);
  localparam logic LiveReset = (INDEX == 0);

  logic tok_q, tok_d;
  logic live_q, live_d;

  // Load the search token at the start slot, else pass it on from the neighbour
  always_comb begin
    tok_d = tok_q;
    if (ctrl_i.load_tok) begin
      tok_d = (ctrl_i.start_idx == MyIdx);
    end else if (ctrl_i.shift_tok) begin
      tok_d = tok_prev_i;
    end
  end

  // Drop the mark on exit of the running slot, set it where a create lands
  always_comb begin
    live_d = live_q;
    if (ctrl_i.clr_run && (ctrl_i.run_idx == MyIdx)) begin
      live_d = 1'b0;
    end else if (ctrl_i.set_live && tok_q) begin
      live_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= 1'b0;
      live_q <= LiveReset;
    end else begin
      tok_q  <= tok_d;
      live_q <= live_d;
    end
  end

  assign tok_o  = tok_q;
  assign live_o = live_q;
  assign hit_o  = tok_q & (ctrl_i.find_free ? ~live_q : live_q);

endmodule

`default_nettype wire

// ===== design/round_robin_thread_slot_scheduler.sv =====
// Yield and exit search the ring from the slot after the running one for the next live slot;
// create searches upward from slot zero for the lowest free slot.
// Failed searches report full or no live slot; bad sizes and unused codes skip the search.
// Words are taken only while idle; the next word is taken while the result strobe is up.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset (asynchronous, active low): slot zero live and running, no search pending.
`default_nettype none

`include "round_robin_thread_slot_scheduler_assert.svh"

module round_robin_thread_slot_scheduler
  import rrts_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start,
  input  cmd_word_t  cmd_i,
  output logic       busy,
  output logic       done_o,
  output res_word_t  result_o
);

  localparam int unsigned SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SlotW-1:0] LastIdx = SlotW'(SLOT_COUNT - 1);

  state_e           state_q, state_d;
  logic [1:0]       cmd_q, cmd_d;
  logic [SlotW-1:0] run_q, run_d;
  logic [SlotW-1:0] probe_q, probe_d;
  logic [SlotW-1:0] count_q, count_d;
  logic             done_q, done_d;
  res_word_t        res_q, res_d;

  cell_ctrl_t            ctrl;
  logic [SLOT_COUNT-1:0] tok_vec;
  logic [SLOT_COUNT-1:0] live_vec;
  logic [SLOT_COUNT-1:0] hit_vec;

  logic             accept;
  logic             size_bad;
  logic             need_seek;
  logic             hit;
  logic             last_step;
  logic [SlotW-1:0] run_next;
  logic [SlotW-1:0] probe_next;

  // Build the ring of slot cells
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    rrts_slot_cell #(
      .INDEX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .tok_prev_i (tok_vec[(i + SLOT_COUNT - 1) % SLOT_COUNT]),
      .tok_o      (tok_vec[i]),
      .live_o     (live_vec[i]),
      .hit_o      (hit_vec[i])
    );
  end

  // Decode the incoming word and the search step
  assign accept     = start && (state_q == SIdle);
  assign size_bad   = (cmd_i.stack_bytes == '0) || (cmd_i.stack_bytes >= StackLimit);
  assign hit        = |hit_vec;
  assign last_step  = (count_q == LastIdx);
  assign run_next   = (run_q == LastIdx) ? '0 : run_q + 1'b1;
  assign probe_next = (probe_q == LastIdx) ? '0 : probe_q + 1'b1;

  always_comb begin
    case (cmd_i.command)
      CmdYield:  need_seek = 1'b1;
      CmdExit:   need_seek = 1'b1;
      CmdCreate: need_seek = !size_bad;
      default:   need_seek = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (accept && need_seek) begin
          state_d = SSeek;
        end
      end
      SSeek: begin
        if (hit || last_step) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // Drive cell control and the result word
  always_comb begin
    ctrl           = '0;
    ctrl.run_idx   = IdxMaxW'(run_q);
    ctrl.find_free = (cmd_q == CmdCreate);
    cmd_d          = cmd_q;
    run_d          = run_q;
    probe_d        = probe_q;
    count_d        = count_q;
    done_d         = 1'b0;
    res_d          = res_q;
    case (state_q)
      SIdle: begin
        if (accept) begin
          cmd_d              = cmd_i.command;
          count_d            = '0;
          res_d.from_slot    = SlotFieldW'(run_q);
          res_d.to_slot      = SlotFieldW'(run_q);
          res_d.created_slot = '0;
          res_d.status       = StOk;
          case (cmd_i.command)
            CmdYield: begin
              ctrl.load_tok  = 1'b1;
              ctrl.start_idx = IdxMaxW'(run_next);
              probe_d        = run_next;
            end
            CmdExit: begin
              ctrl.load_tok  = 1'b1;
              ctrl.clr_run   = 1'b1;
              ctrl.start_idx = IdxMaxW'(run_next);
              probe_d        = run_next;
            end
            CmdCreate: begin
              if (size_bad) begin
                res_d.status = StBadSize;
                done_d       = 1'b1;
              end else begin
                ctrl.load_tok  = 1'b1;
                ctrl.start_idx = '0;
                probe_d        = '0;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      SSeek: begin
        if (hit) begin
          done_d = 1'b1;
          if (cmd_q == CmdCreate) begin
            ctrl.set_live      = 1'b1;
            res_d.created_slot = SlotFieldW'(probe_q);
          end else begin
            run_d         = probe_q;
            res_d.to_slot = SlotFieldW'(probe_q);
          end
        end else if (last_step) begin
          done_d       = 1'b1;
          res_d.status = (cmd_q == CmdCreate) ? StFull : StNoLive;
        end else begin
          ctrl.shift_tok = 1'b1;
          probe_d        = probe_next;
          count_d        = count_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      run_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      run_q   <= run_d;
      done_q  <= done_d;
    end
  end

  // Hold the search and result payload
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    probe_q <= probe_d;
    count_q <= count_d;
    res_q   <= res_d;
  end

  assign busy     = (state_q == SSeek);
  assign done_o   = done_q;
  assign result_o = res_q;

  `RRTS_ASSERT(a_token_single, (state_q != SSeek) || $onehot0(tok_vec),
               "more than one search token in the ring")
  `RRTS_ASSERT(a_done_cause, !done_o || $past(busy || start),
               "result word without a command or a search")
  `RRTS_ASSERT_NEXT(a_yield_live, (state_q == SSeek) && hit && (cmd_q != CmdCreate),
                    live_vec[run_q], "yield landed on a slot that is not live")

endmodule

`default_nettype wire
